// ===== sv/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  localparam int unsigned COEF_W_DEF = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam logic [1:0] KIND_REAL2   = 2'd0;
  localparam logic [1:0] KIND_EQUAL   = 2'd1;
  localparam logic [1:0] KIND_COMPLEX = 2'd2;
  localparam logic [1:0] KIND_DEGEN   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       degen;
    logic       d_neg;
  } qrs_ctrl_t;

endpackage

// ===== sv/qrs_disc.sv =====
// Discriminant stage: squares and products, then magnitude and sign of b*b-4ac.
module qrs_disc #(
  parameter int unsigned CW = qrs_pkg::COEF_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [CW-1:0]   a,
  input  logic signed [CW-1:0]   b,
  input  logic signed [CW-1:0]   c,
  output logic                   out_vld,
  output logic signed [CW-1:0]   a_o,
  output logic signed [CW-1:0]   b_o,
  output logic [2*CW+1:0]        dmag_o,
  output qrs_pkg::qrs_ctrl_t     ctl_o
);
  import qrs_pkg::*;

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned DW = 2 * CW + 2;

  logic [CW-1:0] ma, mb, mc;
  logic [PW-1:0] b2_r, ac_r;
  logic          acpos_r, v1_r;
  logic signed [CW-1:0] a1_r, b1_r;
  logic [DW-1:0] m4, b2w, dmag_r;
  logic          dneg;
  qrs_ctrl_t     ctl_r;
  logic          v2_r;
  logic signed [CW-1:0] a2_r, b2o_r;

  assign ma = a[CW-1] ? CW'(-a) : CW'(a);
  assign mb = b[CW-1] ? CW'(-b) : CW'(b);
  assign mc = c[CW-1] ? CW'(-c) : CW'(c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_r    <= PW'(mb) * PW'(mb);
      ac_r    <= PW'(ma) * PW'(mc);
      acpos_r <= (c != '0) && (a[CW-1] == c[CW-1]);
      a1_r    <= a;
      b1_r    <= b;
    end
  end

  assign m4  = {ac_r, 2'b00};
  assign b2w = DW'(b2_r);
  assign dneg = acpos_r && (m4 > b2w);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!acpos_r)      dmag_r <= b2w + m4;
      else if (dneg)     dmag_r <= m4 - b2w;
      else               dmag_r <= b2w - m4;
      ctl_r.degen <= (a1_r == '0);
      ctl_r.d_neg <= dneg;
      if (a1_r == '0)                          ctl_r.kind <= KIND_DEGEN;
      else if (dneg)                           ctl_r.kind <= KIND_COMPLEX;
      else if (!acpos_r ? (b2w + m4) == '0 : (b2w == m4)) ctl_r.kind <= KIND_EQUAL;
      else                                     ctl_r.kind <= KIND_REAL2;
      a2_r  <= a1_r;
      b2o_r <= b1_r;
    end
  end

  assign out_vld = v2_r;
  assign a_o     = a2_r;
  assign b_o     = b2o_r;
  assign dmag_o  = dmag_r;
  assign ctl_o   = ctl_r;
endmodule

// ===== sv/qrs_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module qrs_sqrt #(
  parameter int unsigned CW = qrs_pkg::COEF_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [2*CW+1:0]      dmag,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  qrs_pkg::qrs_ctrl_t   ctl,
  output logic                 out_vld,
  output logic [CW:0]          root_o,
  output logic signed [CW-1:0] a_o,
  output logic signed [CW-1:0] b_o,
  output qrs_pkg::qrs_ctrl_t   ctl_o
);
  import qrs_pkg::*;

  localparam int unsigned DW = 2 * CW + 2;
  localparam int unsigned NS = CW + 1;
  localparam int unsigned RW = CW + 3;

  logic [DW-1:0]        rad_r  [1:NS];
  logic [RW-1:0]        rem_r  [1:NS];
  logic [CW:0]          root_r [1:NS];
  logic signed [CW-1:0] a_r    [1:NS];
  logic signed [CW-1:0] b_r    [1:NS];
  qrs_ctrl_t            ctl_r  [1:NS];
  logic                 v_r    [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [DW-1:0]        rad_c;
    logic [RW-1:0]        rem_c, rm, tr;
    logic [CW:0]          root_c;
    logic signed [CW-1:0] a_c, b_c;
    qrs_ctrl_t            ctl_c;
    logic                 v_c;
    if (i == 0) begin : g_head
      assign rad_c  = dmag;
      assign rem_c  = '0;
      assign root_c = '0;
      assign a_c    = a;
      assign b_c    = b;
      assign ctl_c  = ctl;
      assign v_c    = in_vld;
    end else begin : g_body
      assign rad_c  = rad_r[i];
      assign rem_c  = rem_r[i];
      assign root_c = root_r[i];
      assign a_c    = a_r[i];
      assign b_c    = b_r[i];
      assign ctl_c  = ctl_r[i];
      assign v_c    = v_r[i];
    end
    assign rm = {rem_c[RW-3:0], rad_c[DW-1:DW-2]};
    assign tr = {root_c[RW-3:0], 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_c;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1] <= {rad_c[DW-3:0], 2'b00};
        if (rm >= tr) begin
          rem_r[i+1]  <= rm - tr;
          root_r[i+1] <= {root_c[CW-1:0], 1'b1};
        end else begin
          rem_r[i+1]  <= rm;
          root_r[i+1] <= {root_c[CW-1:0], 1'b0};
        end
        a_r[i+1]   <= a_c;
        b_r[i+1]   <= b_c;
        ctl_r[i+1] <= ctl_c;
      end
    end
  end

  assign out_vld = v_r[NS];
  assign root_o  = root_r[NS];
  assign a_o     = a_r[NS];
  assign b_o     = b_r[NS];
  assign ctl_o   = ctl_r[NS];
endmodule

// ===== sv/qrs_div.sv =====
// Pipelined signed restoring divider: (num << 16) / den, truncated, Q16.16 saturation.
module qrs_div #(
  parameter int unsigned NW = 18,
  parameter int unsigned EW = 18,
  parameter int unsigned XW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] num,
  input  logic signed [EW-1:0] den,
  input  logic [XW-1:0]        side,
  output logic                 out_vld,
  output logic [31:0]          q_o,
  output logic                 sat_o,
  output logic [XW-1:0]        side_o
);
  import qrs_pkg::*;

  localparam int unsigned QW = NW + FRAC_SHIFT;
  localparam int unsigned RW = EW + 1;

  logic [QW-1:0]  q_r   [1:QW];
  logic [RW-1:0]  rm_r  [1:QW];
  logic [EW-1:0]  d_r   [1:QW];
  logic           ng_r  [1:QW];
  logic [XW-1:0]  sd_r  [1:QW];
  logic           v_r   [1:QW];

  logic [NW-1:0] mn;
  logic [EW-1:0] md;
  assign mn = num[NW-1] ? NW'(-num) : NW'(num);
  assign md = den[EW-1] ? EW'(-den) : EW'(den);

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW-1:0] q_c;
    logic [RW-1:0] rm_c, sh;
    logic [EW-1:0] d_c;
    logic          ng_c;
    logic [XW-1:0] sd_c;
    logic          v_c;
    if (i == 0) begin : g_head
      assign q_c  = {mn, FRAC_SHIFT'(0)};
      assign rm_c = '0;
      assign d_c  = md;
      assign ng_c = num[NW-1] ^ den[EW-1];
      assign sd_c = side;
      assign v_c  = in_vld;
    end else begin : g_body
      assign q_c  = q_r[i];
      assign rm_c = rm_r[i];
      assign d_c  = d_r[i];
      assign ng_c = ng_r[i];
      assign sd_c = sd_r[i];
      assign v_c  = v_r[i];
    end
    assign sh = {rm_c[RW-2:0], q_c[QW-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_c;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= RW'(d_c)) begin
          rm_r[i+1] <= sh - RW'(d_c);
          q_r[i+1]  <= {q_c[QW-2:0], 1'b1};
        end else begin
          rm_r[i+1] <= sh;
          q_r[i+1]  <= {q_c[QW-2:0], 1'b0};
        end
        d_r[i+1]  <= d_c;
        ng_r[i+1] <= ng_c;
        sd_r[i+1] <= sd_c;
      end
    end
  end

  logic [QW:0] qm;
  logic        big;
  assign qm  = {1'b0, q_r[QW]};
  assign big = ng_r[QW] ? (qm > (QW+1)'(64'h8000_0000))
                        : (qm > (QW+1)'(64'h7FFF_FFFF));

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else if (en) out_vld <= v_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_o  <= big;
      side_o <= sd_r[QW];
      if (big)            q_o <= ng_r[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else if (ng_r[QW])  q_o <= 32'(-qm);
      else                q_o <= 32'(qm);
    end
  end
endmodule

// ===== sv/quadratic_root_solver.sv =====
// Quadratic root solver: discriminant, square root, three dividers and output skid.
// Throughput: one coefficient set per cycle; the whole pipe advances while the
// skid entry is empty, the output register plus one skid entry absorb back pressure.
// Reset: rst_n synchronous, active low, clears all valid bits; payload is not reset.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::COEF_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] in_tdata,  // coef_a, coef_b, coef_c
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [103:0]          out_tdata  // root_kind, root_one, root_two, imag_part, saturated
);
  import qrs_pkg::*;

  localparam int unsigned CW  = COEF_WIDTH;
  localparam int unsigned NW  = CW + 2;
  localparam int unsigned EW  = CW + 1;
  localparam int unsigned ODW = 2 + 3 * OUT_W + 1;

  logic en;
  logic signed [CW-1:0] ca, cb, cc;
  assign ca = in_tdata[CW-1:0];
  assign cb = in_tdata[2*CW-1:CW];
  assign cc = in_tdata[3*CW-1:2*CW];

  logic                 d_v;
  logic signed [CW-1:0] d_a, d_b;
  logic [2*CW+1:0]      d_mag;
  qrs_ctrl_t            d_ctl;

  qrs_disc #(.CW(CW)) u_disc (
    .clk, .rst_n, .en, .in_vld(in_tvalid && in_tready),
    .a(ca), .b(cb), .c(cc),
    .out_vld(d_v), .a_o(d_a), .b_o(d_b), .dmag_o(d_mag), .ctl_o(d_ctl)
  );

  logic                 s_v;
  logic [CW:0]          s_root;
  logic signed [CW-1:0] s_a, s_b;
  qrs_ctrl_t            s_ctl;

  qrs_sqrt #(.CW(CW)) u_sqrt (
    .clk, .rst_n, .en, .in_vld(d_v), .dmag(d_mag), .a(d_a), .b(d_b), .ctl(d_ctl),
    .out_vld(s_v), .root_o(s_root), .a_o(s_a), .b_o(s_b), .ctl_o(s_ctl)
  );

  logic signed [NW-1:0] nb, sr, n1, n2, n3;
  logic signed [EW-1:0] den;
  assign nb  = -NW'(s_b);
  assign sr  = NW'({1'b0, s_root});
  assign den = EW'(s_a) <<< 1;
  assign n1  = (s_ctl.kind == KIND_REAL2) ? nb + sr : nb;
  assign n2  = (s_ctl.kind == KIND_REAL2) ? nb - sr : nb;
  assign n3  = (s_ctl.kind == KIND_COMPLEX) ? sr : '0;

  logic        q_v, q_v2, q_v3;
  logic [31:0] q1, q2, q3;
  logic        st1, st2, st3;
  qrs_ctrl_t   q_ctl;
  logic [3:0]  x2, x3;

  qrs_div #(.NW(NW), .EW(EW), .XW(4)) u_div1 (
    .clk, .rst_n, .en, .in_vld(s_v), .num(n1), .den(den), .side(s_ctl),
    .out_vld(q_v), .q_o(q1), .sat_o(st1), .side_o(q_ctl)
  );
  qrs_div #(.NW(NW), .EW(EW), .XW(4)) u_div2 (
    .clk, .rst_n, .en, .in_vld(s_v), .num(n2), .den(den), .side(s_ctl),
    .out_vld(q_v2), .q_o(q2), .sat_o(st2), .side_o(x2)
  );
  qrs_div #(.NW(NW), .EW(EW), .XW(4)) u_div3 (
    .clk, .rst_n, .en, .in_vld(s_v), .num(n3), .den(den), .side(s_ctl),
    .out_vld(q_v3), .q_o(q3), .sat_o(st3), .side_o(x3)
  );

  logic [ODW-1:0] res;
  always_comb begin
    if (q_ctl.degen) res = {1'b0, 96'd0, KIND_DEGEN};
    else res = {st1 | st2 | st3, q3, q2, q1, q_ctl.kind};
  end

  // output register plus one skid entry
  logic           o_v_r, s_v_r;
  logic [ODW-1:0] o_d_r, s_d_r;
  logic           pv;
  assign pv = q_v & q_v2 & q_v3 & (x2 == x3);
  assign en = !s_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      if (!o_v_r || out_tready) begin
        if (s_v_r) begin
          o_v_r <= 1'b1;
          s_v_r <= 1'b0;
        end else begin
          o_v_r <= en && pv;
        end
      end else if (en && pv) begin
        s_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!o_v_r || out_tready) begin
      if (s_v_r) o_d_r <= s_d_r;
      else       o_d_r <= res;
    end else if (en && pv) begin
      s_d_r <= res;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {{(104-ODW){1'b0}}, o_d_r};
endmodule

// ===== sv/qrs_checker.sv =====
// Port-level checker for the quadratic root solver, bound to the top level.
module qrs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);
  import qrs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_DEGEN |-> out_tdata[98:2] == '0)
    else $error("degenerate result not zero");

  a_real_im: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == KIND_REAL2 || out_tdata[1:0] == KIND_EQUAL)
    |-> out_tdata[97:66] == '0)
    else $error("imaginary part set for real roots");

  a_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == KIND_EQUAL || out_tdata[1:0] == KIND_COMPLEX)
    |-> out_tdata[33:2] == out_tdata[65:34])
    else $error("paired roots differ");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:99] == '0)
    else $error("padding bits set");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

// ===== tb/sv/tb.sv =====
// Testbench for quadratic_root_solver: directed table plus random coefficient sets.
`timescale 1ns / 100ps

module tb;
  import qrs_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] root_one;
    logic [31:0] root_two;
    logic [31:0] imag_part;
    logic        saturated;
  } roots_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    bit          typed;
    roots_t      roots;
  } coef_row_t;

  localparam int DIR_N = 14;
  localparam coef_row_t COEF_TAB [DIR_N] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{KIND_DEGEN, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{16'sd0,      -16'sd32768, 16'sd32767,  1'b1, '{KIND_DEGEN, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{16'sd256,    16'sd0,      16'sd0,      1'b1, '{KIND_EQUAL, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{16'sd256,    16'sd0,      -16'sd256,   1'b1,
      '{KIND_REAL2, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 1'b0}},
    '{16'sd256,    16'sd0,      16'sd256,    1'b1,
      '{KIND_COMPLEX, 32'd0, 32'd0, 32'h0001_0000, 1'b0}},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd1,      -16'sd32768, 16'sd0,      1'b0, '0},
    '{-16'sd1,     16'sd32767,  -16'sd32768, 1'b0, '0},
    '{16'sd1,      16'sd0,      16'sd32767,  1'b0, '0},
    '{-16'sd32768, 16'sd0,      16'sd32767,  1'b0, '0},
    '{16'sd32767,  -16'sd32768, -16'sd32768, 1'b0, '0},
    '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, '0},
    '{16'sd1,      16'sd1,      16'sd1,      1'b0, '0}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;   // coef_a, coef_b, coef_c
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // root_kind, root_one, root_two, imag_part, saturated

  roots_t roots_q[$];
  int     n_err;
  int     n_sent;
  int     n_got;
  int     in_idle;
  int     out_idle;
  int     hold_cycles;
  longint n_cyc;

  quadratic_root_solver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c);
    longint sa, sb, sc, disc, mag, s, den, r1, r2, im, t;
    bit     flag;
    roots_t r;
    sa = 64'(a);
    sb = 64'(b);
    sc = 64'(c);
    r = '0;
    flag = 1'b0;
    if (sa == 0) begin
      r.kind = KIND_DEGEN;
      return r;
    end
    disc = sb * sb - 4 * sa * sc;
    mag = (disc < 0) ? -disc : disc;
    s = 0;
    for (int k = 20; k >= 0; k--) begin
      t = s | (64'sd1 << k);
      if (t * t <= mag) s = t;
    end
    den = 2 * sa;
    im = 0;
    if (disc < 0) begin
      r.kind = KIND_COMPLEX;
      r1 = clip32((-sb * 65536) / den, flag);
      r2 = r1;
      im = clip32((s * 65536) / den, flag);
    end else if (disc == 0) begin
      r.kind = KIND_EQUAL;
      r1 = clip32((-sb * 65536) / den, flag);
      r2 = r1;
    end else begin
      r.kind = KIND_REAL2;
      r1 = clip32(((-sb + s) * 65536) / den, flag);
      r2 = clip32(((-sb - s) * 65536) / den, flag);
    end
    r.root_one = r1[31:0];
    r.root_two = r2[31:0];
    r.imag_part = im[31:0];
    r.saturated = flag;
    return r;
  endfunction

  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit typed,
                            roots_t typed_roots);
    while ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c, b, a};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    roots_q.push_back(typed ? typed_roots : solve_roots(a, b, c));
    n_sent++;
  endtask

  task automatic send_random(int n);
    logic signed [15:0] a, b, c;
    int sel, r;
    for (int i = 0; i < n; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      sel = $urandom_range(9);
      if (sel == 0) begin
        a = '0;
      end else if (sel <= 2) begin
        // repeated root: a*(x-r)^2
        a = 16'($urandom_range(1, 60));
        if ($urandom_range(1)) a = -a;
        r = $urandom_range(0, 20);
        if ($urandom_range(1)) r = -r;
        b = 16'(-2 * a * r);
        c = 16'(a * r * r);
      end else if (sel == 3) begin
        a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        b = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        c = 16'($urandom);
      end else if (sel <= 5) begin
        a = $signed(16'($urandom_range(0, 511))) - 16'sd256;
        if (a == 16'sd0) a = 16'sd1;
        b = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
        c = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      end
      send_coefs(a, b, c, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    roots_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind      = out_tdata[1:0];
      got.root_one  = out_tdata[33:2];
      got.root_two  = out_tdata[65:34];
      got.imag_part = out_tdata[97:66];
      got.saturated = out_tdata[98];
      n_got++;
      if (roots_q.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        n_err++;
      end else begin
        want = roots_q.pop_front();
        if (got.kind != want.kind) begin
          $error("root_kind exp %0d got %0d", want.kind, got.kind);
          n_err++;
        end
        if (got.root_one != want.root_one) begin
          $error("root_one exp %h got %h", want.root_one, got.root_one);
          n_err++;
        end
        if (got.root_two != want.root_two) begin
          $error("root_two exp %h got %h", want.root_two, got.root_two);
          n_err++;
        end
        if (got.imag_part != want.imag_part) begin
          $error("imag_part exp %h got %h", want.imag_part, got.imag_part);
          n_err++;
        end
        if (got.saturated != want.saturated) begin
          $error("saturated exp %0d got %0d", want.saturated, got.saturated);
          n_err++;
        end
      end
    end
  end

  // receiver back pressure, with an optional long hold
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle);
      end
    end
  end

  initial begin
    n_cyc = 0;
    forever begin
      @(posedge clk);
      n_cyc++;
      if (n_cyc > 500000) begin
        $display("timeout: %0d outstanding", roots_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    n_err = 0;
    n_sent = 0;
    n_got = 0;
    in_idle = 0;
    out_idle = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (COEF_TAB[i])
      send_coefs(COEF_TAB[i].a, COEF_TAB[i].b, COEF_TAB[i].c, COEF_TAB[i].typed,
                 COEF_TAB[i].roots);

    in_idle = 10;
    out_idle = 61;
    send_random(300);
    hold_cycles = 400;
    send_random(300);
    in_tvalid <= 1'b0;
    wait (roots_q.size() == 0);
    @(posedge clk);

    in_idle = 61;
    out_idle = 10;
    send_random(550);

    in_idle = 0;
    out_idle = 0;
    send_random(300);
    hold_cycles = 300;
    send_random(250);
    in_tvalid <= 1'b0;

    wait (roots_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("%0d coefficient sets sent, %0d root sets checked", n_sent, n_got);
    $display("covered degenerate, equal, real and complex roots, clipping, long stalls");
    if (n_err == 0 && roots_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== quadratic_root_solver.f =====
sv/qrs_pkg.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
sv/qrs_checker.sv
tb/sv/tb.sv
